// ===== src/pss_pkg.sv =====
// Package with the shared constants and word types of the price set statistics block.
`default_nettype none
package pss_pkg;

    localparam int MAX_ORDERS = 256;
    localparam int ADDR_W = $clog2(MAX_ORDERS);
    localparam int CNT_W = $clog2(MAX_ORDERS + 1);
    localparam int PRICE_W = 32;
    localparam int FRAC_W = 16;
    localparam int SUM_W = PRICE_W + ADDR_W;
    localparam int WSUM_W = PRICE_W + FRAC_W + ADDR_W;
    localparam int TOTAL_W = 40;
    localparam int COUNT_W = 9;
    localparam int BIT_W = $clog2(PRICE_W);

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [PRICE_W-1:0] amount;
        logic               last_order;
    } order_t;

    typedef struct packed {
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] mean_price;
        logic [PRICE_W-1:0] median_price;
        logic [TOTAL_W-1:0] total_amount;
        logic [PRICE_W-1:0] weighted_average;
        logic [COUNT_W-1:0] order_count;
        logic               overflowed;
    } result_t;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   num_hi;
        logic [PRICE_W-1:0] num_lo;
        logic [SUM_W-1:0]   divisor;
    } div_req_t;

endpackage
`default_nettype wire

// ===== src/price_set_statistics.sv =====
// Top level of the price set statistics block with VWAP.
//
// Orders enter on the order word: a word is taken at a clock edge where start
// is high and busy is low. Orders of one set load at one per cycle; each price
// is written into the price store and the sums, high and low are updated.
// Once the word marked last_order is taken, busy rises and the block computes
// the mean and the VWAP with a one-bit-per-cycle divider and the median by a
// bitwise rank search over the store, one pass per price bit, 32 passes for
// an odd count n and 64 for an even one. The result word is shown for exactly
// one cycle with result_valid high, in the same cycle that busy falls; the
// receiver cannot stall it. Orders beyond the store capacity are dropped and
// flagged in overflowed. Reset clears the running set state and returns the
// block to loading.
`default_nettype none
module price_set_statistics (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pss_pkg::order_t  order,
    output logic                  result_valid,
    output pss_pkg::result_t      result
);

    typedef enum logic [2:0] {S_LOAD, S_FLUSH, S_MEAN, S_WAVG, S_MEDIAN} state_t;

    localparam logic [pss_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

    state_t                        state_reg, state_next;
    logic                          busy_reg, busy_next;
    logic                          valid_reg, valid_next;
    logic                          drop_reg, drop_next;
    logic                          prod_v_reg, prod_v_next;
    logic                          med_have_reg, med_have_next;
    logic [pss_pkg::CNT_W-1:0]     kept_reg, kept_next;
    logic [pss_pkg::SUM_W-1:0]     ptot_reg, ptot_next;
    logic [pss_pkg::SUM_W-1:0]     atot_reg, atot_next;
    logic [pss_pkg::WSUM_W-1:0]    wtot_reg, wtot_next;
    logic [pss_pkg::PRICE_W-1:0]   high_reg, high_next;
    logic [pss_pkg::PRICE_W-1:0]   low_reg, low_next;
    logic [2*pss_pkg::PRICE_W-1:0] prod_reg, prod_next;
    logic [pss_pkg::PRICE_W-1:0]   mean_reg, mean_next;
    logic [pss_pkg::PRICE_W-1:0]   wavg_reg, wavg_next;
    logic [pss_pkg::PRICE_W-1:0]   med_reg, med_next;
    pss_pkg::result_t              result_reg, result_next;

    logic                          accept;
    logic                          keep;
    logic                          wsat;
    logic [pss_pkg::SUM_W-1:0]     whigh;
    pss_pkg::div_req_t             div_req;
    logic                          div_done;
    logic [pss_pkg::PRICE_W-1:0]   div_q;
    logic                          med_start;
    logic                          med_done;
    logic [pss_pkg::PRICE_W-1:0]   med_value;
    logic                          rd_en;
    logic [pss_pkg::ADDR_W-1:0]    rd_addr;
    logic [pss_pkg::PRICE_W-1:0]   rd_data;

    assign accept = start && !busy_reg;
    assign keep = kept_reg < pss_pkg::CNT_W'(pss_pkg::MAX_ORDERS);
    assign whigh = wtot_reg[pss_pkg::WSUM_W-1:pss_pkg::FRAC_W];
    assign wsat = whigh >= atot_reg;

    pss_ram #(
        .WIDTH(pss_pkg::PRICE_W),
        .DEPTH(pss_pkg::MAX_ORDERS)
    ) u_store (
        .clk(clk),
        .wr_en(accept && keep),
        .wr_addr(kept_reg[pss_pkg::ADDR_W-1:0]),
        .wr_data(order.price),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    pss_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .req(div_req),
        .done(div_done),
        .quotient(div_q)
    );

    pss_median u_median (
        .clk(clk),
        .rst_n(rst_n),
        .start(med_start),
        .count(kept_reg),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .done(med_done),
        .median(med_value)
    );

    always_comb
    begin
        state_next = state_reg;
        busy_next = busy_reg;
        valid_next = 1'b0;
        drop_next = drop_reg;
        prod_v_next = 1'b0;
        med_have_next = med_have_reg || med_done;
        kept_next = kept_reg;
        ptot_next = ptot_reg;
        atot_next = atot_reg;
        wtot_next = wtot_reg;
        high_next = high_reg;
        low_next = low_reg;
        prod_next = prod_reg;
        mean_next = mean_reg;
        wavg_next = wavg_reg;
        med_next = med_done ? med_value : med_reg;
        result_next = result_reg;
        med_start = 1'b0;
        div_req.start = 1'b0;
        div_req.num_hi = pss_pkg::SUM_W'(ptot_reg >> pss_pkg::PRICE_W);
        div_req.num_lo = ptot_reg[pss_pkg::PRICE_W-1:0];
        div_req.divisor = pss_pkg::SUM_W'(kept_reg);

        if (prod_v_reg)
        begin
            wtot_next = wtot_reg
                        + pss_pkg::WSUM_W'(prod_reg[2*pss_pkg::PRICE_W-1:pss_pkg::FRAC_W]);
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (keep)
                    begin
                        kept_next = kept_reg + 1'b1;
                        ptot_next = ptot_reg + pss_pkg::SUM_W'(order.price);
                        atot_next = atot_reg + pss_pkg::SUM_W'(order.amount);
                        prod_next = pss_pkg::PRICE_W'(order.price) * order.amount;
                        prod_v_next = 1'b1;
                        if (order.price > high_reg)
                        begin
                            high_next = order.price;
                        end
                        if (order.price < low_reg)
                        begin
                            low_next = order.price;
                        end
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (order.last_order)
                    begin
                        busy_next = 1'b1;
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                div_req.start = 1'b1;
                med_start = 1'b1;
                med_have_next = 1'b0;
                state_next = S_MEAN;
            end
            S_MEAN:
            begin
                div_req.num_hi = whigh;
                div_req.num_lo = {wtot_reg[pss_pkg::FRAC_W-1:0], pss_pkg::FRAC_W'(0)};
                div_req.divisor = atot_reg;
                if (div_done)
                begin
                    mean_next = div_q;
                    if (atot_reg == '0)
                    begin
                        wavg_next = '0;
                        state_next = S_MEDIAN;
                    end
                    else if (wsat)
                    begin
                        wavg_next = '1;
                        state_next = S_MEDIAN;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next = S_WAVG;
                    end
                end
            end
            S_WAVG:
            begin
                if (div_done)
                begin
                    wavg_next = div_q;
                    state_next = S_MEDIAN;
                end
            end
            S_MEDIAN:
            begin
                if (med_have_reg)
                begin
                    result_next.high_price = high_reg;
                    result_next.low_price = low_reg;
                    result_next.mean_price = mean_reg;
                    result_next.median_price = med_reg;
                    result_next.total_amount =
                        (64'(atot_reg) > 64'(TOTAL_MAX)) ? TOTAL_MAX
                                                         : pss_pkg::TOTAL_W'(atot_reg);
                    result_next.weighted_average = wavg_reg;
                    result_next.order_count = pss_pkg::COUNT_W'(kept_reg);
                    result_next.overflowed = drop_reg;
                    valid_next = 1'b1;
                    busy_next = 1'b0;
                    kept_next = '0;
                    ptot_next = '0;
                    atot_next = '0;
                    wtot_next = '0;
                    high_next = '0;
                    low_next = '1;
                    drop_next = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            busy_reg <= 1'b0;
            valid_reg <= 1'b0;
            drop_reg <= 1'b0;
            prod_v_reg <= 1'b0;
            med_have_reg <= 1'b0;
            kept_reg <= '0;
            ptot_reg <= '0;
            atot_reg <= '0;
            wtot_reg <= '0;
            high_reg <= '0;
            low_reg <= '1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= busy_next;
            valid_reg <= valid_next;
            drop_reg <= drop_next;
            prod_v_reg <= prod_v_next;
            med_have_reg <= med_have_next;
            kept_reg <= kept_next;
            ptot_reg <= ptot_next;
            atot_reg <= atot_next;
            wtot_reg <= wtot_next;
            high_reg <= high_next;
            low_reg <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        mean_reg <= mean_next;
        wavg_reg <= wavg_next;
        med_reg <= med_next;
        result_reg <= result_next;
    end

    assign busy = busy_reg;
    assign result_valid = valid_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== src/pss_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module pss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/pss_div.sv =====
// Restoring divider that produces a 32-bit quotient, one bit per cycle.
`default_nettype none
module pss_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pss_pkg::div_req_t          req,
    output logic                            done,
    output logic [pss_pkg::PRICE_W-1:0]     quotient
);

    logic                            run_reg, run_next;
    logic                            done_reg, done_next;
    logic [pss_pkg::BIT_W-1:0]       step_reg, step_next;
    logic [pss_pkg::SUM_W-1:0]       rem_reg, rem_next;
    logic [pss_pkg::SUM_W-1:0]       div_reg, div_next;
    logic [pss_pkg::PRICE_W-1:0]     lo_reg, lo_next;
    logic [pss_pkg::SUM_W:0]         trial;
    logic                            ge;

    always_comb
    begin
        trial = {rem_reg, lo_reg[pss_pkg::PRICE_W-1]};
        ge = trial >= {1'b0, div_reg};
        run_next = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        lo_next = lo_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            step_next = '0;
            rem_next = req.num_hi;
            div_next = req.divisor;
            lo_next = req.num_lo;
        end
        else if (run_reg)
        begin
            rem_next = ge ? pss_pkg::SUM_W'(trial - {1'b0, div_reg})
                          : trial[pss_pkg::SUM_W-1:0];
            lo_next = {lo_reg[pss_pkg::PRICE_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == '1)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        lo_reg <= lo_next;
    end

    assign done = done_reg;
    assign quotient = lo_reg;

endmodule
`default_nettype wire

// ===== src/pss_median.sv =====
// Median finder that selects ranked prices from the store one bit per pass.
`default_nettype none
module pss_median (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pss_pkg::CNT_W-1:0]   count,
    output logic                             rd_en,
    output logic      [pss_pkg::ADDR_W-1:0]  rd_addr,
    input  wire logic [pss_pkg::PRICE_W-1:0] rd_data,
    output logic                             done,
    output logic      [pss_pkg::PRICE_W-1:0] median
);

    typedef enum logic {M_IDLE, M_SCAN} mstate_t;

    mstate_t                       state_reg, state_next;
    logic                          done_reg, done_next;
    logic                          dv_reg, dv_next;
    logic                          second_reg, second_next;
    logic [pss_pkg::CNT_W-1:0]     n_reg, n_next;
    logic [pss_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic [pss_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [pss_pkg::CNT_W-1:0]     k_reg, k_next;
    logic [pss_pkg::BIT_W-1:0]     bit_reg, bit_next;
    logic [pss_pkg::PRICE_W-1:0]   prefix_reg, prefix_next;
    logic [pss_pkg::PRICE_W-1:0]   mask_reg, mask_next;
    logic [pss_pkg::PRICE_W-1:0]   first_reg, first_next;
    logic [pss_pkg::PRICE_W-1:0]   median_reg, median_next;
    logic [pss_pkg::PRICE_W-1:0]   bit_onehot;
    logic [pss_pkg::PRICE_W-1:0]   chosen;
    logic [pss_pkg::CNT_W-1:0]     cnt_sum;
    logic [pss_pkg::PRICE_W:0]     pair_sum;
    logic                          match;

    always_comb
    begin
        bit_onehot = pss_pkg::PRICE_W'(1) << bit_reg;
        match = dv_reg && (((rd_data ^ prefix_reg) & mask_reg) == '0)
                && !rd_data[bit_reg];
        cnt_sum = cnt_reg + pss_pkg::CNT_W'(match);
        chosen = (k_reg < cnt_sum) ? prefix_reg : (prefix_reg | bit_onehot);
        pair_sum = {1'b0, first_reg} + {1'b0, chosen};
        rd_en = (state_reg == M_SCAN) && (idx_reg != n_reg);
        rd_addr = idx_reg[pss_pkg::ADDR_W-1:0];

        state_next = state_reg;
        done_next = 1'b0;
        dv_next = rd_en;
        second_next = second_reg;
        n_next = n_reg;
        idx_next = rd_en ? idx_reg + 1'b1 : idx_reg;
        cnt_next = cnt_sum;
        k_next = k_reg;
        bit_next = bit_reg;
        prefix_next = prefix_reg;
        mask_next = mask_reg;
        first_next = first_reg;
        median_next = median_reg;

        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_SCAN;
                    second_next = 1'b0;
                    n_next = count;
                    idx_next = '0;
                    cnt_next = '0;
                    k_next = count >> 1;
                    bit_next = '1;
                    prefix_next = '0;
                    mask_next = '0;
                end
            end
            M_SCAN:
            begin
                if (idx_reg == n_reg)
                begin
                    idx_next = '0;
                    cnt_next = '0;
                    prefix_next = chosen;
                    mask_next = mask_reg | bit_onehot;
                    bit_next = bit_reg - 1'b1;
                    if (k_reg >= cnt_sum)
                    begin
                        k_next = k_reg - cnt_sum;
                    end
                    if (bit_reg == '0)
                    begin
                        prefix_next = '0;
                        mask_next = '0;
                        if (!n_reg[0] && !second_reg)
                        begin
                            second_next = 1'b1;
                            first_next = chosen;
                            k_next = (n_reg >> 1) - 1'b1;
                        end
                        else
                        begin
                            state_next = M_IDLE;
                            done_next = 1'b1;
                            median_next = second_reg ? pair_sum[pss_pkg::PRICE_W:1] : chosen;
                        end
                    end
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg <= 1'b0;
            dv_reg <= 1'b0;
            second_reg <= 1'b0;
            n_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            k_reg <= '0;
            bit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            dv_reg <= dv_next;
            second_reg <= second_next;
            n_reg <= n_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            k_reg <= k_next;
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
        mask_reg <= mask_next;
        first_reg <= first_next;
        median_reg <= median_next;
    end

    assign done = done_reg;
    assign median = median_reg;

endmodule
`default_nettype wire

// ===== src/pss_checker.sv =====
// Port-level checker for the price set statistics block and its bind.
`default_nettype none
module pss_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire pss_pkg::order_t  order,
    input wire logic             result_valid,
    input wire pss_pkg::result_t result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && order.last_order) |=> busy)
        else $error("busy did not rise after the last order word");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result word shown while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy fell without a result word");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.low_price <= result.median_price
                          && result.median_price <= result.high_price
                          && result.low_price <= result.mean_price
                          && result.mean_price <= result.high_price))
        else $error("median or mean outside the low to high range");

endmodule

bind price_set_statistics pss_checker u_pss_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .order(order),
    .result_valid(result_valid),
    .result(result)
);
`default_nettype wire

// ===== bench/price_set_checker.sv =====
// Checker that predicts and compares the statistics words of the price set statistics block.
`timescale 1ns / 100ps
`default_nettype none
module price_set_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire pss_pkg::order_t   order,
    input  wire logic              result_valid,
    input  wire pss_pkg::result_t  result,
    input  wire logic              end_of_run,
    output int                     fail_count,
    output int                     pending
);

    logic [pss_pkg::PRICE_W-1:0] price_mem [pss_pkg::MAX_ORDERS];
    int unsigned                 held;
    logic [63:0]                 sum_price;
    logic [63:0]                 sum_amount;
    logic [63:0]                 sum_weighted;
    logic [pss_pkg::PRICE_W-1:0] run_high;
    logic [pss_pkg::PRICE_W-1:0] run_low;
    bit                          lost;
    pss_pkg::result_t            stats_q [$];
    int                          mismatches;
    int                          leftover;

    task automatic clear_set();
        held = 0;
        sum_price = '0;
        sum_amount = '0;
        sum_weighted = '0;
        run_high = '0;
        run_low = '1;
        lost = 0;
    endtask

    task automatic take_order(input pss_pkg::order_t w);
        logic [pss_pkg::PRICE_W-1:0] sorted [$];
        logic [32:0]                 pair;
        logic [127:0]                quo;
        pss_pkg::result_t            r;
        if (held < pss_pkg::MAX_ORDERS)
        begin
            price_mem[held] = w.price;
            held++;
            sum_price += w.price;
            sum_amount += w.amount;
            sum_weighted += ({32'b0, w.price} * {32'b0, w.amount}) >> pss_pkg::FRAC_W;
            if (w.price > run_high)
                run_high = w.price;
            if (w.price < run_low)
                run_low = w.price;
        end
        else
            lost = 1;
        if (w.last_order)
        begin
            for (int i = 0; i < held; i++)
                sorted = {sorted, price_mem[i]};
            sorted.sort();
            r.high_price = run_high;
            r.low_price = run_low;
            r.mean_price = 32'(sum_price / held);
            if (held % 2 == 0)
            begin
                pair = {1'b0, sorted[held/2]} + {1'b0, sorted[held/2-1]};
                r.median_price = pair[32:1];
            end
            else
                r.median_price = sorted[held/2];
            r.total_amount = (sum_amount > 64'hFF_FFFF_FFFF) ? '1
                                                             : sum_amount[pss_pkg::TOTAL_W-1:0];
            if (sum_amount == 0)
                r.weighted_average = '0;
            else
            begin
                quo = ({64'b0, sum_weighted} << pss_pkg::FRAC_W) / {64'b0, sum_amount};
                r.weighted_average = (quo > 128'hFFFF_FFFF) ? '1 : quo[31:0];
            end
            r.order_count = held[pss_pkg::COUNT_W-1:0];
            r.overflowed = lost;
            stats_q = {stats_q, r};
            clear_set();
        end
    endtask

    initial
    begin
        mismatches = 0;
        leftover = 0;
        clear_set();
    end

    always @(posedge clk)
    begin
        pss_pkg::result_t e;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (stats_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word %h", result);
                end
                else
                begin
                    e = stats_q.pop_front();
                    if (e.high_price !== result.high_price
                        || e.low_price !== result.low_price
                        || e.mean_price !== result.mean_price
                        || e.median_price !== result.median_price
                        || e.total_amount !== result.total_amount
                        || e.weighted_average !== result.weighted_average
                        || e.order_count !== result.order_count
                        || e.overflowed !== result.overflowed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h actual %h", e, result);
                    end
                end
            end
            if (start && !busy)
                take_order(order);
        end
    end

    always @(posedge end_of_run)
        leftover = stats_q.size();

    assign fail_count = mismatches + leftover;
    assign pending = stats_q.size();
endmodule
`default_nettype wire

// ===== bench/tb_price_set_statistics.sv =====
// Top of the testbench that drives order words into the price set statistics block.
`timescale 1ns / 100ps
`default_nettype none
module tb_price_set_statistics;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             start = 0;
    logic             busy;
    pss_pkg::order_t  order = '0;
    logic             result_valid;
    pss_pkg::result_t result;
    logic             end_of_run = 0;
    int               fail_count;
    int               pending;
    int               cycles = 0;
    int               sent = 0;
    int               big_sets = 0;
    bit               quiet = 0;

    price_set_statistics dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .order(order), .result_valid(result_valid), .result(result)
    );

    price_set_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .order(order),
        .result_valid(result_valid), .result(result), .end_of_run(end_of_run),
        .fail_count(fail_count), .pending(pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_order(input logic [31:0] p, input logic [31:0] a, input logic l);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            start <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        start <= 1;
        order <= '{price: p, amount: a, last_order: l};
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    function automatic logic [31:0] pick_value();
        unique case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            4: return $urandom_range(32'h0001_0000, 32'h00FF_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n, input bit zero_amount);
        for (int i = 0; i < n; i++)
            send_order(pick_value(), zero_amount ? 32'h0 : pick_value(), i == n - 1);
    endtask

    task automatic wait_drained();
        start <= 0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_order(32'h0, 32'h0, 1);
        send_order(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send_order(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_order(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1);
        send_order(32'h0, 32'hFFFF_FFFF, 0);
        send_order(32'hFFFF_FFFF, 32'h0, 1);
        send_order(32'h0001_8000, 32'h0002_0000, 0);
        send_order(32'h0000_0001, 32'h0000_0001, 0);
        send_order(32'h0003_0000, 32'h0000_0000, 1);
        send_order(32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_order(32'hAAAA_AAAA, 32'h5555_5555, 0);
        send_order(32'h1234_5678, 32'h0000_0000, 0);
        send_order(32'h8765_4321, 32'h0000_0000, 1);
        send_set(4, 1);

        while (sent < 1350)
        begin
            if (sent > 1200)
                quiet = 1;
            if (sent > 600 && sent < 620)
                wait_drained();
            if (big_sets < 3 && $urandom_range(0, 60) == 0)
            begin
                n = (big_sets == 0) ? 256 : (big_sets == 1) ? 259 : 255;
                big_sets++;
            end
            else
                n = $urandom_range(1, 8);
            send_set(n, $urandom_range(0, 12) == 0);
        end

        wait_drained();
        repeat (200) @(posedge clk);
        end_of_run <= 1;
        @(posedge clk);
        @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
